/* rtl/core/tbe_pkg.sv */
// ----------------------------------------------------------------------------
// Three-band equalizer package
// Shared widths, payload types, register indexes and the command bundle that
// the controller sends to the datapath.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = 17;
  localparam int POLE_W   = 32;
  localparam int OPA_W    = 34;
  localparam int OPB_W    = 18;
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int ACC_W    = PROD_W + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [COEF_W-1:0]          coef_t;
  typedef logic signed [POLE_W-1:0]   pole_t;
  typedef logic [0:0]                 cfg_idx_t;

  localparam cfg_idx_t CFG_LOW_COEF  = 1'b0;
  localparam cfg_idx_t CFG_HIGH_COEF = 1'b1;

  localparam coef_t LOW_COEF_RST  = 17'd7549;
  localparam coef_t HIGH_COEF_RST = 17'd42586;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_POLE,
    MUL_LOW_GAIN,
    MUL_MID_GAIN,
    MUL_HIGH_GAIN
  } mul_op_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       rd_hi;
    logic [1:0] rd_stage;
    mul_op_t    mul_op;
    logic       mul_hi;
    logic [1:0] mul_stage;
    logic       fin;
  } dp_cmd_t;

endpackage

/* rtl/core/tbe_in_if.sv */
// ----------------------------------------------------------------------------
// Equalizer input channel
// Valid/ready channel carrying one sample with its channel and band gains.
// ----------------------------------------------------------------------------
interface tbe_in_if;
  import tbe_pkg::*;

  logic    valid;
  logic    ready;
  logic    channel;
  sample_t sample_in;
  gain_t   low_gain;
  gain_t   mid_gain;
  gain_t   high_gain;

  modport source (output valid, channel, sample_in, low_gain, mid_gain, high_gain,
                  input ready);
  modport sink   (input valid, channel, sample_in, low_gain, mid_gain, high_gain,
                  output ready);
endinterface

/* rtl/core/tbe_out_if.sv */
// ----------------------------------------------------------------------------
// Equalizer result channel
// Valid/ready channel carrying one equalized sample and its channel.
// ----------------------------------------------------------------------------
interface tbe_out_if;
  import tbe_pkg::*;

  logic    valid;
  logic    ready;
  logic    channel_out;
  sample_t sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

/* rtl/core/three_band_equalizer.sv */
// ----------------------------------------------------------------------------
// Three-band equalizer
// Per-channel low/mid/high split with cascaded one-pole filters and gain mix.
// ----------------------------------------------------------------------------
// Each accepted transaction runs until its result sits in the output
// register, and the input is ready again in that same cycle; one transaction
// is in flight at a time. The pace of each transaction is set by the
// single shared 34x18 multiplier, which runs the eight pole updates (low and
// high chains interleaved so each update meets its predecessor's result) and
// the three gain products in turn, fed by the one-read, one-write pole
// memory. A result waiting on the output does not block the next input, but
// the following result waits until the output register is taken. Reset
// clears all filter state and restores the default cutoff coefficients;
// coefficient writes take effect at once and belong between transactions.
module three_band_equalizer #(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  tbe_in_if.sink            in_ch,
  tbe_out_if.source         out_ch,
  input  logic              cfg_we,
  input  tbe_pkg::cfg_idx_t cfg_index,
  input  tbe_pkg::coef_t    cfg_data
);
  import tbe_pkg::*;

  dp_cmd_t cmd;

  tbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tbe_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_channel   (in_ch.channel),
    .in_sample    (in_ch.sample_in),
    .in_low_gain  (in_ch.low_gain),
    .in_mid_gain  (in_ch.mid_gain),
    .in_high_gain (in_ch.high_gain),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_channel  (out_ch.channel_out),
    .out_sample   (out_ch.sample_out)
  );

endmodule

/* rtl/core/tbe_ctrl.sv */
// ----------------------------------------------------------------------------
// Equalizer controller
// Sequences pole reads, the shared multiplier and the output register for
// one transaction at a time, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output tbe_pkg::dp_cmd_t cmd
);
  import tbe_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  localparam logic [3:0] STEP_LAST_RD   = 4'd7;
  localparam logic [3:0] STEP_LAST_POLE = 4'd8;
  localparam logic [3:0] STEP_LOW_GAIN  = 4'd9;
  localparam logic [3:0] STEP_MID_GAIN  = 4'd10;
  localparam logic [3:0] STEP_HIGH_GAIN = 4'd11;
  localparam logic [3:0] STEP_FIN       = 4'd13;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [3:0] step_m1;
  logic       out_valid_r, out_valid_nxt;

  assign step_m1 = step_r - 4'd1;

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_NONE;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 4'd1;
        // prefetch the pole in the step before its multiply; chains alternate
        if (step_r <= STEP_LAST_RD) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_hi    = step_r[0];
          cmd.rd_stage = step_r[2:1];
        end
        if (step_r != '0 && step_r <= STEP_LAST_POLE) begin
          cmd.mul_op    = MUL_POLE;
          cmd.mul_hi    = step_m1[0];
          cmd.mul_stage = step_m1[2:1];
        end
        case (step_r)
          STEP_LOW_GAIN:  cmd.mul_op = MUL_LOW_GAIN;
          STEP_MID_GAIN:  cmd.mul_op = MUL_MID_GAIN;
          STEP_HIGH_GAIN: cmd.mul_op = MUL_HIGH_GAIN;
          default: ;
        endcase
        if (step_r == STEP_FIN) begin
          // hold until the output register is free
          step_nxt = step_r;
          if (!out_valid_r || out_ready) begin
            cmd.fin       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/tbe_datapath.sv */
// ----------------------------------------------------------------------------
// Equalizer datapath
// Coefficient registers, per-channel delay line, pole memory, one shared
// multiplier with its update and accumulate stage, and the output register.
// ----------------------------------------------------------------------------
module tbe_datapath #(
  parameter int CHANNELS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbe_pkg::dp_cmd_t cmd,
  input  logic             in_channel,
  input  tbe_pkg::sample_t in_sample,
  input  tbe_pkg::gain_t   in_low_gain,
  input  tbe_pkg::gain_t   in_mid_gain,
  input  tbe_pkg::gain_t   in_high_gain,
  input  logic             cfg_we,
  input  tbe_pkg::cfg_idx_t cfg_index,
  input  tbe_pkg::coef_t   cfg_data,
  output logic             out_channel,
  output tbe_pkg::sample_t out_sample
);
  import tbe_pkg::*;

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW     = CW + 3;
  localparam int PDEPTH = 1 << AW;
  localparam int STEP_W = PROD_W - 16;
  localparam int SUM_W  = STEP_W + 1;
  localparam int Y_W    = ACC_W - 20;

  localparam logic signed [PROD_W-1:0] POLE_RND = PROD_W'(32768);
  localparam logic signed [ACC_W-1:0]  OUT_RND  = ACC_W'(524288);
  localparam pole_t   POLE_MAX = {1'b0, {(POLE_W-1){1'b1}}};
  localparam pole_t   POLE_MIN = {1'b1, {(POLE_W-1){1'b0}}};
  localparam sample_t SAMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // configuration and control state
  coef_t          low_coef_r, high_coef_r;
  sample_t        hist_r [CHANNELS][3];
  logic [PDEPTH-1:0] pvld_r;
  logic           rd_vld_r;
  mul_op_t        op_r;
  logic           op_hi_r;
  logic [1:0]     op_stage_r;

  // payload
  pole_t          pole_mem [PDEPTH];
  pole_t          rd_data_r;
  logic           chan_r;
  logic [CW-1:0]  cidx_r;
  gain_t          lg_r, mg_r, hg_r;
  sample_t        d3_r;
  pole_t          low_in_r, high_in_r;
  logic signed [PROD_W-1:0] prod_r;
  pole_t          p_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic           out_channel_r;
  sample_t        out_sample_r;

  logic [CW-1:0]  in_cidx;
  logic [AW-1:0]  rd_addr, wr_addr;
  pole_t          pole_q, d3_ext, xs;
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [STEP_W-1:0] pole_step;
  logic signed [SUM_W-1:0]  pole_sum;
  pole_t          pole_new;
  logic           pole_we;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Y_W-1:0]    y_wide;
  sample_t        y;

  always_comb begin
    if (CHANNELS > 1) begin
      in_cidx = CW'(in_channel);
    end else begin
      in_cidx = '0;
    end
  end

  assign rd_addr = {cidx_r, cmd.rd_hi, cmd.rd_stage};
  assign wr_addr = {cidx_r, op_hi_r, op_stage_r};
  assign pole_q  = rd_vld_r ? rd_data_r : '0;
  assign d3_ext  = pole_t'({d3_r, 8'h00});
  assign xs      = pole_t'({in_sample, 8'h00});

  // shared multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul_op)
      MUL_POLE: begin
        if (cmd.mul_hi) begin
          opa = OPA_W'(high_in_r) - OPA_W'(pole_q);
          opb = {1'b0, high_coef_r};
        end else begin
          opa = OPA_W'(low_in_r) - OPA_W'(pole_q);
          opb = {1'b0, low_coef_r};
        end
      end
      MUL_LOW_GAIN: begin
        opa = OPA_W'(low_in_r);
        opb = {2'b00, lg_r};
      end
      MUL_MID_GAIN: begin
        opa = OPA_W'(high_in_r) - OPA_W'(low_in_r);
        opb = {2'b00, mg_r};
      end
      MUL_HIGH_GAIN: begin
        opa = OPA_W'(d3_ext) - OPA_W'(high_in_r);
        opb = {2'b00, hg_r};
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;

  // pole update: round half up, drop 16 fraction bits, saturate to 32 bits
  assign prod_rnd  = prod_r + POLE_RND;
  assign pole_step = prod_rnd[PROD_W-1:16];
  assign pole_sum  = SUM_W'(p_r) + SUM_W'(pole_step);

  always_comb begin
    if (pole_sum > SUM_W'(POLE_MAX)) begin
      pole_new = POLE_MAX;
    end else if (pole_sum < SUM_W'(POLE_MIN)) begin
      pole_new = POLE_MIN;
    end else begin
      pole_new = pole_sum[POLE_W-1:0];
    end
  end

  assign pole_we = (op_r == MUL_POLE);

  // final rounding and saturation of the weighted sum
  assign acc_rnd = acc_r + OUT_RND;
  assign y_wide  = acc_rnd[ACC_W-1:20];

  always_comb begin
    if (y_wide > Y_W'(SAMP_MAX)) begin
      y = SAMP_MAX;
    end else if (y_wide < Y_W'(SAMP_MIN)) begin
      y = SAMP_MIN;
    end else begin
      y = y_wide[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_coef_r  <= LOW_COEF_RST;
      high_coef_r <= HIGH_COEF_RST;
      pvld_r      <= '0;
      rd_vld_r    <= 1'b0;
      op_r        <= MUL_NONE;
      op_hi_r     <= 1'b0;
      op_stage_r  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < 3; k++) begin
          hist_r[c][k] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOW_COEF) begin
          low_coef_r <= cfg_data;
        end else if (cfg_index == CFG_HIGH_COEF) begin
          high_coef_r <= cfg_data;
        end
      end
      if (cmd.load) begin
        hist_r[in_cidx][2] <= hist_r[in_cidx][1];
        hist_r[in_cidx][1] <= hist_r[in_cidx][0];
        hist_r[in_cidx][0] <= in_sample;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= pvld_r[rd_addr];
      end
      if (pole_we) begin
        pvld_r[wr_addr] <= 1'b1;
      end
      op_r       <= cmd.mul_op;
      op_hi_r    <= cmd.mul_hi;
      op_stage_r <= cmd.mul_stage;
    end
  end

  // pole memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (pole_we) begin
      pole_mem[wr_addr] <= pole_new;
    end
    if (cmd.rd_en) begin
      rd_data_r <= pole_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_r    <= in_channel;
      cidx_r    <= in_cidx;
      lg_r      <= in_low_gain;
      mg_r      <= in_mid_gain;
      hg_r      <= in_high_gain;
      d3_r      <= hist_r[in_cidx][2];
      low_in_r  <= xs;
      high_in_r <= xs;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= prod;
      p_r    <= pole_q;
    end
    if (pole_we) begin
      if (op_hi_r) begin
        high_in_r <= pole_new;
      end else begin
        low_in_r <= pole_new;
      end
    end
    case (op_r)
      MUL_LOW_GAIN:  acc_r <= ACC_W'(prod_r);
      MUL_MID_GAIN,
      MUL_HIGH_GAIN: acc_r <= acc_r + ACC_W'(prod_r);
      default: ;
    endcase
    if (cmd.fin) begin
      out_channel_r <= chan_r;
      out_sample_r  <= y;
    end
  end

  assign out_channel = out_channel_r;
  assign out_sample  = out_sample_r;

endmodule

/* rtl/core/tbe_checker.sv */
// ----------------------------------------------------------------------------
// Equalizer port checker
// Concurrent checks on the equalizer's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module tbe_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             channel_out,
  input tbe_pkg::sample_t sample_out
);
  import tbe_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(channel_out))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one transaction in flight: no back-to-back acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input accepted while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_valid))
    else $error("result appeared straight after acceptance");

endmodule

bind three_band_equalizer tbe_checker u_tbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .channel_out (out_ch.channel_out),
  .sample_out  (out_ch.sample_out)
);

/* tb/three_band_equalizer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band equalizer testbench
// Drives samples with band gains over the valid/ready input, predicts every
// equalized sample with a cycle-free model of the filter chains and delay
// lines (or takes a known row's value from the table), and compares each
// result in order. A short stimulus table opens the run, then random traffic
// under several coefficient settings and idling patterns follows.
// ----------------------------------------------------------------------------
module three_band_equalizer_test;
  import tbe_pkg::*;

  localparam int     NUM_CH      = 2;
  localparam int     LOW_BAND    = 0;
  localparam int     HIGH_BAND   = 1;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 225;
  localparam int     QUIET_LIMIT = 5000;
  localparam longint POLE_MAX    = 64'sd2147483647;
  localparam longint POLE_MIN    = -64'sd2147483648;
  localparam longint SAMPLE_MAX  = 64'sd8388607;
  localparam longint SAMPLE_MIN  = -64'sd8388608;
  localparam coef_t  COEF_MAX    = '1;

  typedef struct {
    logic    channel;
    sample_t sample;
    gain_t   low_gain;
    gain_t   mid_gain;
    gain_t   high_gain;
  } eq_item_t;

  typedef struct {
    logic    channel;
    sample_t sample;
  } eq_result_t;

  typedef struct {
    eq_item_t item;
    bit       known;
    sample_t  want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  coef_t cfg_data;

  tbe_in_if  in_ch ();
  tbe_out_if out_ch ();

  three_band_equalizer #(.CHANNELS(NUM_CH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state: coefficients, pole chains [band][channel][stage], delay lines
  coef_t   low_coef;
  coef_t   high_coef;
  pole_t   poles [2][NUM_CH][4];
  sample_t history [NUM_CH][3];

  eq_result_t eq_outputs_due[$];
  stim_row_t  stim_table[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct;
  int         stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint run_poles(input int band, input int ch, input longint coef,
                                       input longint x);
    longint stage_in;
    longint p;
    longint np;
    stage_in = x;
    for (int k = 0; k < 4; k++) begin
      p  = poles[band][ch][k];
      np = p + ((coef * (stage_in - p) + 64'sd32768) >>> 16);
      if (np > POLE_MAX) np = POLE_MAX;
      else if (np < POLE_MIN) np = POLE_MIN;
      poles[band][ch][k] = pole_t'(np);
      stage_in = np;
    end
    return stage_in;
  endfunction

  function automatic eq_result_t equalize(input eq_item_t it);
    int         ch;
    longint     xs;
    longint     d3;
    longint     lo;
    longint     hi;
    longint     mid;
    longint     acc;
    longint     y;
    eq_result_t r;
    ch  = int'(it.channel) % NUM_CH;
    xs  = longint'(it.sample) * 256;
    d3  = longint'(history[ch][2]) * 256;
    lo  = run_poles(LOW_BAND, ch, longint'(low_coef), xs);
    hi  = d3 - run_poles(HIGH_BAND, ch, longint'(high_coef), xs);
    mid = d3 - (hi + lo);
    acc = lo * longint'(it.low_gain) + mid * longint'(it.mid_gain)
        + hi * longint'(it.high_gain);
    y   = (acc + 64'sd524288) >>> 20;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    history[ch][2] = history[ch][1];
    history[ch][1] = history[ch][0];
    history[ch][0] = it.sample;
    r.channel = it.channel;
    r.sample  = sample_t'(y);
    return r;
  endfunction

  task automatic add_row(input logic ch, input int s, input int lg, input int mg,
                         input int hg, input bit known, input int want);
    stim_row_t row;
    row.item.channel   = ch;
    row.item.sample    = sample_t'(s);
    row.item.low_gain  = gain_t'(lg);
    row.item.mid_gain  = gain_t'(mg);
    row.item.high_gain = gain_t'(hg);
    row.known          = known;
    row.want           = sample_t'(want);
    stim_table.push_back(row);
  endtask

  function automatic gain_t random_gain();
    case ($urandom_range(4))
      0: begin
        case ($urandom_range(2))
          0:       return gain_t'(0);
          1:       return gain_t'(4096);
          default: return gain_t'(65535);
        endcase
      end
      1, 2:    return gain_t'($urandom_range(0, 8192));
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic eq_item_t random_item();
    eq_item_t it;
    it.channel = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       it.sample = sample_t'(SAMPLE_MAX);
          1:       it.sample = sample_t'(SAMPLE_MIN);
          2:       it.sample = '0;
          default: it.sample = '1;
        endcase
      end
      1, 2:    it.sample = sample_t'(int'($urandom_range(0, 131071)) - 65536);
      default: it.sample = sample_t'($urandom);
    endcase
    it.low_gain  = random_gain();
    it.mid_gain  = random_gain();
    it.high_gain = random_gain();
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_item(input eq_item_t it, input bit known, input sample_t want);
    int         gap;
    eq_result_t r;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(4) == 0) gap = $urandom_range(1, 24);
    while (gap > 0 || $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      if (gap > 0) gap--;
    end
    in_ch.valid     <= 1'b1;
    in_ch.channel   <= it.channel;
    in_ch.sample_in <= it.sample;
    in_ch.low_gain  <= it.low_gain;
    in_ch.mid_gain  <= it.mid_gain;
    in_ch.high_gain <= it.high_gain;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = equalize(it);
    if (known) r.sample = want;
    eq_outputs_due.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    while (eq_outputs_due.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_coefficients(input coef_t lo_c, input coef_t hi_c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_COEF;
    cfg_data  <= lo_c;
    low_coef   = lo_c;
    @(negedge clk);
    cfg_index <= CFG_HIGH_COEF;
    cfg_data  <= hi_c;
    high_coef  = hi_c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result receiver: stall at random, then check each transaction in order
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    eq_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (eq_outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got channel %0d sample %0d",
                 $time, out_ch.channel_out, out_ch.sample_out);
      end else begin
        due = eq_outputs_due.pop_front();
        if (out_ch.channel_out !== due.channel) begin
          mismatches++;
          $display("%0t: channel mismatch, expected %0d, got %0d",
                   $time, due.channel, out_ch.channel_out);
        end
        if (out_ch.sample_out !== due.sample) begin
          mismatches++;
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, due.sample, out_ch.sample_out);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    coef_t lo_c;
    coef_t hi_c;
    in_ch.valid     = 1'b0;
    in_ch.channel   = 1'b0;
    in_ch.sample_in = '0;
    in_ch.low_gain  = '0;
    in_ch.mid_gain  = '0;
    in_ch.high_gain = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LOW_COEF;
    cfg_data        = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    low_coef        = LOW_COEF_RST;
    high_coef       = HIGH_COEF_RST;
    for (int b = 0; b < 2; b++)
      for (int c = 0; c < NUM_CH; c++)
        for (int k = 0; k < 4; k++) poles[b][c][k] = '0;
    for (int c = 0; c < NUM_CH; c++)
      for (int k = 0; k < 3; k++) history[c][k] = '0;

    // Equal gains collapse the bands to the sample three transactions back on
    // that channel, scaled by the gain: unity returns it exactly, zero gives
    // nothing, full scale saturates.
    add_row(1'b0,  8388607,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b0, -8388608,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b0,  1234567,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b0,        0,  4096,  4096,  4096, 1'b1,  8388607);
    add_row(1'b1,       -1,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b0,        0,  4096,  4096,  4096, 1'b1, -8388608);
    add_row(1'b0,  8388607,     0,     0,     0, 1'b1,        0);
    add_row(1'b0, -8388608, 65535, 65535, 65535, 1'b1,        0);
    add_row(1'b0,        0, 65535, 65535, 65535, 1'b1,        0);
    add_row(1'b0,        0, 65535, 65535, 65535, 1'b1,  8388607);
    add_row(1'b0,        0, 65535, 65535, 65535, 1'b1, -8388608);
    add_row(1'b1,        5,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b1,        7,  4096,  4096,  4096, 1'b1,        0);
    add_row(1'b1,        0,  4096,  4096,  4096, 1'b1,       -1);
    // Single bands, mixed gains and alternating bit patterns
    add_row(1'b0,  8388607, 65535,     0,     0, 1'b0, 0);
    add_row(1'b0, -8388608,     0, 65535,     0, 1'b0, 0);
    add_row(1'b0,  8388607,     0,     0, 65535, 1'b0, 0);
    add_row(1'b1,     4660,  4096,  8192,  2048, 1'b0, 0);
    add_row(1'b1, -8388608, 65535, 65535,     0, 1'b0, 0);
    add_row(1'b0, 'h555555, 'hAAAA, 'h5555, 'hFFFF, 1'b0, 0);
    add_row(1'b1, -'h555556, 'h5555, 'hAAAA,    0, 1'b0, 0);
    add_row(1'b0,        1,     1,     1,     1, 1'b0, 0);
    add_row(1'b1,       -1, 65535,     1, 32768, 1'b0, 0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) drive_item(stim_table[i].item, stim_table[i].known,
                                       stim_table[i].want);
    in_ch.valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain(4);
      case (phase)
        0: begin lo_c = LOW_COEF_RST; hi_c = HIGH_COEF_RST; end
        1: begin lo_c = '0; hi_c = '0; end
        2: begin lo_c = COEF_MAX; hi_c = COEF_MAX; end
        3: begin lo_c = coef_t'($urandom); hi_c = coef_t'($urandom); end
        4: begin lo_c = coef_t'(1); hi_c = COEF_MAX; end
        5: begin lo_c = COEF_MAX; hi_c = '0; end
        6: begin
          lo_c = coef_t'($urandom_range(0, 8192));
          hi_c = coef_t'($urandom_range(0, 65536));
        end
        default: begin lo_c = LOW_COEF_RST; hi_c = HIGH_COEF_RST; end
      endcase
      set_coefficients(lo_c, hi_c);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 70; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) drive_item(random_item(), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    drain(32);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tbe_pkg.sv
rtl/core/tbe_in_if.sv
rtl/core/tbe_out_if.sv
rtl/core/tbe_ctrl.sv
rtl/core/tbe_datapath.sv
rtl/core/three_band_equalizer.sv
rtl/core/tbe_checker.sv
tb/three_band_equalizer_test.sv
